@@ rtl/bale_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and constants for the bounded array list engine.
// Used by bale_ctrl, bale_datapath and bounded_array_list_engine_top.
package bale_pkg;

  // Default store depth and capacity register reset value
  localparam int unsigned DEPTH_DEFAULT = 64;
  localparam logic [6:0]  CAP_RESET     = 7'd64;

  // Field widths of a transfer
  localparam int unsigned IN_W  = 48;  // 42 bits of fields, padded to 6 bytes
  localparam int unsigned OUT_W = 48;  // 48 bits of fields

  typedef enum logic [3:0] {
    OP_READ      = 4'd0,
    OP_WRITE     = 4'd1,
    OP_APPEND    = 4'd2,
    OP_REM_LAST  = 4'd3,
    OP_INS_AT    = 4'd4,
    OP_REM_AT    = 4'd5,
    OP_INS_FRONT = 4'd6,
    OP_REM_FRONT = 4'd7,
    OP_CLEAR     = 4'd8,
    OP_SEARCH_GT = 4'd9
  } opcode_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_BAD_INDEX = 2'd1,
    ST_FULL      = 2'd2,
    ST_EMPTY     = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    LEN_HOLD = 2'd0,
    LEN_INC  = 2'd1,
    LEN_DEC  = 2'd2,
    LEN_CLR  = 2'd3
  } len_op_t;

  // Write address source for a direct store write
  typedef enum logic [1:0] {
    WA_POS  = 2'd0,
    WA_LEN  = 2'd1,
    WA_BASE = 2'd2
  } wr_addr_t;

  // Controller to datapath commands
  typedef struct packed {
    logic     capture;     // latch the input item, clear working results
    logic     use_front;   // walk base is 0 instead of position
    logic     setup_up;    // prepare tail move up (insert)
    logic     setup_down;  // prepare tail move down (remove)
    logic     setup_srch;  // prepare search walk
    logic     step;        // advance the walk
    logic     mem_wr;      // direct write of operand value
    wr_addr_t wr_sel;
    logic     rd_pos;      // read store at position
    logic     cap_rdata;   // keep read data for the result
    len_op_t  len_op;
    logic     status_we;
    status_t  status_code;
    logic     res_load;    // move working result into output register
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic [3:0] op;
    logic       full;
    logic       empty;
    logic       idx_ok;
    logic       walk_done;
    logic       search_done;
    logic       out_free;
  } sts_t;

endpackage

@@ rtl/bounded_array_list_engine_top.sv @@
`timescale 1ns / 1ps
// Top level of the bounded array list engine.
// Instantiates bale_ctrl and bale_datapath; depends on bale_pkg.
//
// The engine keeps an ordered list of signed 32-bit words in a DEPTH-entry
// single-port-read RAM and runs one opcode per input transfer, returning one
// result transfer. Items are handled one at a time: a new item is taken when
// the controller is back in idle, even while the previous result still sits
// in the output register. Write, append, remove last, clear and unused
// opcodes are carried out in the decode state; read then waits in S_RDWAIT
// for the registered RAM data. Insert and remove move the tail one element
// per cycle through the RAM read port (read one entry, write it back shifted
// the next cycle, overlapped); at most DEPTH - 1 elements move. Search reads
// one element per cycle and stops at the first hit, or at the end of the
// list when nothing is greater. Errors are decided in the decode state. The
// next item can be accepted in the cycle after the result is loaded; a
// result held by m_tready low stalls the following one in the controller.
// Errors (bad index, full, empty) leave the list untouched. capacity_limit
// resets to 64 and is capped at DEPTH; write it only while the engine is idle.
module bounded_array_list_engine_top #(
  parameter int unsigned DEPTH = bale_pkg::DEPTH_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  // opcode[3:0], position[9:4], operand_value[41:10], zero pad
  input  logic [47:0] s_tdata,
  input  logic        s_tvalid,
  output logic        s_tready,
  // status[1:0], read_data[33:2], found[34], found_index[40:35],
  // element_count[47:41]
  output logic [47:0] m_tdata,
  output logic        m_tvalid,
  input  logic        m_tready,
  // capacity_limit write
  input  logic        cfg_wr_en,
  input  logic [6:0]  cfg_wr_data
);

  bale_pkg::cmd_t cmd;
  bale_pkg::sts_t sts;

  bale_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  bale_datapath #(
    .DEPTH (DEPTH)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .s_tdata     (s_tdata),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .m_tready    (m_tready),
    .m_tvalid    (m_tvalid),
    .m_tdata     (m_tdata),
    .cmd         (cmd),
    .sts         (sts)
  );

endmodule

@@ rtl/bale_datapath.sv @@
`timescale 1ns / 1ps
// Datapath of the array list engine: element store, length, capacity,
// walk pointers and result registers. Depends on bale_pkg.
module bale_datapath #(
  parameter int unsigned DEPTH = bale_pkg::DEPTH_DEFAULT
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic [bale_pkg::IN_W-1:0]  s_tdata,
  input  logic                       cfg_wr_en,
  input  logic [6:0]                 cfg_wr_data,
  input  logic                       m_tready,
  output logic                       m_tvalid,
  output logic [bale_pkg::OUT_W-1:0] m_tdata,
  input  bale_pkg::cmd_t             cmd,
  output bale_pkg::sts_t             sts
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  typedef enum logic [1:0] {
    M_UP   = 2'd0,
    M_DOWN = 2'd1,
    M_SRCH = 2'd2
  } walk_mode_t;

  function automatic logic [AW-1:0] to_addr(input logic [31:0] v);
    return v[AW-1:0];
  endfunction

  // Latched item
  logic [3:0]  op;
  logic [5:0]  pos;
  logic [31:0] val;

  // List state
  logic [6:0]  len;
  logic [6:0]  cap;
  logic [31:0] store [DEPTH];
  logic [31:0] mem_q;

  // Walk state
  logic [5:0]    base;
  logic [AW-1:0] rd_ptr;
  logic [AW-1:0] pend_idx;
  logic [6:0]    rem;
  logic          wpend;
  walk_mode_t    mode;

  // Working result
  bale_pkg::status_t status_r;
  logic [31:0]       rdata_r;
  logic              found;
  logic [5:0]        fidx;

  // Output register
  bale_pkg::status_t out_status;
  logic [31:0]       out_rdata;
  logic              out_found;
  logic [5:0]        out_fidx;
  logic [6:0]        out_count;

  logic [31:0]   len_w, pos_w, cap_eff, pend_w;
  logic [5:0]    p;
  logic          step_rd, step_wr;
  logic          mem_we, mem_re;
  logic [AW-1:0] wr_addr, rd_addr;
  logic [31:0]   wr_data;

  // Checks on the latched item
  always_comb begin
    len_w   = 32'(len);
    pos_w   = 32'(pos);
    pend_w  = 32'(pend_idx);
    cap_eff = (32'(cap) < DEPTH) ? 32'(cap) : DEPTH;
    p       = cmd.use_front ? 6'd0 : pos;
  end

  assign sts.op          = op;
  assign sts.full        = (len_w >= cap_eff);
  assign sts.empty       = (len == 7'd0);
  assign sts.idx_ok      = (pos_w < len_w) && (pos_w < DEPTH);
  assign sts.walk_done   = (rem == 7'd0) && !wpend;
  assign sts.search_done = found || ((rem == 7'd0) && !wpend);
  assign sts.out_free    = !m_tvalid || m_tready;

  // Store port selection
  always_comb begin
    step_rd = cmd.step && (rem != 7'd0);
    step_wr = cmd.step && wpend && (mode != M_SRCH);
    mem_re  = step_rd || cmd.rd_pos;
    rd_addr = cmd.rd_pos ? to_addr(pos_w) : rd_ptr;
    mem_we  = step_wr || cmd.mem_wr;
    wr_data = step_wr ? mem_q : val;
    wr_addr = pend_idx;
    if (!step_wr) begin
      case (cmd.wr_sel)
        bale_pkg::WA_POS:  wr_addr = to_addr(pos_w);
        bale_pkg::WA_LEN:  wr_addr = to_addr(len_w);
        bale_pkg::WA_BASE: wr_addr = to_addr(32'(base));
        default:           wr_addr = to_addr(pos_w);
      endcase
    end
  end

  // Element store, registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      store[wr_addr] <= wr_data;
    end
    if (mem_re) begin
      mem_q <= store[rd_addr];
    end
  end

  // Item latch and walk pointers
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op  <= s_tdata[3:0];
      pos <= s_tdata[9:4];
      val <= s_tdata[41:10];
    end
    if (cmd.setup_up) begin
      rd_ptr <= to_addr(len_w - 32'd1);
      rem    <= len - 7'(p);
      mode   <= M_UP;
      base   <= p;
    end else if (cmd.setup_down) begin
      rd_ptr <= to_addr(32'(p) + 32'd1);
      rem    <= len - 7'd1 - 7'(p);
      mode   <= M_DOWN;
      base   <= p;
    end else if (cmd.setup_srch) begin
      rd_ptr <= '0;
      rem    <= len;
      mode   <= M_SRCH;
    end else if (step_rd) begin
      rem <= rem - 7'd1;
      unique case (mode)
        M_UP: begin
          rd_ptr   <= rd_ptr - AW'(1);
          pend_idx <= rd_ptr + AW'(1);
        end
        M_DOWN: begin
          rd_ptr   <= rd_ptr + AW'(1);
          pend_idx <= rd_ptr - AW'(1);
        end
        default: begin
          rd_ptr   <= rd_ptr + AW'(1);
          pend_idx <= rd_ptr;
        end
      endcase
    end
  end

  // Control registers: pending flag, length, capacity, result flags
  always_ff @(posedge clk) begin
    if (rst) begin
      wpend    <= 1'b0;
      len      <= 7'd0;
      cap      <= bale_pkg::CAP_RESET;
      found    <= 1'b0;
      status_r <= bale_pkg::ST_OK;
      m_tvalid <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        cap <= cfg_wr_data;
      end
      if (cmd.setup_up || cmd.setup_down || cmd.setup_srch) begin
        wpend <= 1'b0;
      end else if (cmd.step) begin
        wpend <= step_rd;
      end
      case (cmd.len_op)
        bale_pkg::LEN_INC: len <= len + 7'd1;
        bale_pkg::LEN_DEC: len <= len - 7'd1;
        bale_pkg::LEN_CLR: len <= 7'd0;
        default:           len <= len;
      endcase
      if (cmd.capture) begin
        found    <= 1'b0;
        status_r <= bale_pkg::ST_OK;
      end else begin
        if (cmd.step && (mode == M_SRCH) && wpend && !found &&
            ($signed(mem_q) > $signed(val))) begin
          found <= 1'b1;
        end
        if (cmd.status_we) begin
          status_r <= cmd.status_code;
        end
      end
      if (cmd.res_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      rdata_r <= 32'd0;
      fidx    <= 6'd0;
    end else begin
      if (cmd.cap_rdata) begin
        rdata_r <= mem_q;
      end
      if (cmd.step && (mode == M_SRCH) && wpend && !found &&
          ($signed(mem_q) > $signed(val))) begin
        fidx <= pend_w[5:0];
      end
    end
    if (cmd.res_load) begin
      out_status <= status_r;
      out_rdata  <= rdata_r;
      out_found  <= found;
      out_fidx   <= fidx;
      out_count  <= len;
    end
  end

  assign m_tdata = {out_count, out_fidx, out_found, out_rdata, out_status};

endmodule

@@ rtl/bale_ctrl.sv @@
`timescale 1ns / 1ps
// Controller state machine of the array list engine: decodes the opcode
// and sequences the datapath. Depends on bale_pkg.
module bale_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           s_tvalid,
  output logic           s_tready,
  input  bale_pkg::sts_t sts,
  output bale_pkg::cmd_t cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_RDWAIT,
    S_SHIFT,
    S_SEARCH,
    S_DONE
  } state_t;

  state_t state, state_next;

  assign s_tready = (state == S_IDLE);

  // Next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (s_tvalid) begin
          cmd.capture = 1'b1;
          state_next  = S_DECODE;
        end
      end
      S_DECODE: begin
        state_next = S_DONE;
        unique case (bale_pkg::opcode_t'(sts.op))
          bale_pkg::OP_READ: begin
            if (sts.idx_ok) begin
              cmd.rd_pos = 1'b1;
              state_next = S_RDWAIT;
            end else begin
              cmd.status_we   = 1'b1;
              cmd.status_code = bale_pkg::ST_BAD_INDEX;
            end
          end
          bale_pkg::OP_WRITE: begin
            if (sts.idx_ok) begin
              cmd.mem_wr = 1'b1;
              cmd.wr_sel = bale_pkg::WA_POS;
            end else begin
              cmd.status_we   = 1'b1;
              cmd.status_code = bale_pkg::ST_BAD_INDEX;
            end
          end
          bale_pkg::OP_APPEND: begin
            if (sts.full) begin
              cmd.status_we   = 1'b1;
              cmd.status_code = bale_pkg::ST_FULL;
            end else begin
              cmd.mem_wr = 1'b1;
              cmd.wr_sel = bale_pkg::WA_LEN;
              cmd.len_op = bale_pkg::LEN_INC;
            end
          end
          bale_pkg::OP_REM_LAST: begin
            if (sts.empty) begin
              cmd.status_we   = 1'b1;
              cmd.status_code = bale_pkg::ST_EMPTY;
            end else begin
              cmd.len_op = bale_pkg::LEN_DEC;
            end
          end
          bale_pkg::OP_INS_AT: begin
            if (sts.full) begin
              cmd.status_we   = 1'b1;
              cmd.status_code = bale_pkg::ST_FULL;
            end else if (!sts.idx_ok) begin
              cmd.status_we   = 1'b1;
              cmd.status_code = bale_pkg::ST_BAD_INDEX;
            end else begin
              cmd.setup_up = 1'b1;
              state_next   = S_SHIFT;
            end
          end
          bale_pkg::OP_REM_AT: begin
            if (!sts.idx_ok) begin
              cmd.status_we   = 1'b1;
              cmd.status_code = bale_pkg::ST_BAD_INDEX;
            end else begin
              cmd.setup_down = 1'b1;
              state_next     = S_SHIFT;
            end
          end
          bale_pkg::OP_INS_FRONT: begin
            if (sts.full) begin
              cmd.status_we   = 1'b1;
              cmd.status_code = bale_pkg::ST_FULL;
            end else begin
              cmd.use_front = 1'b1;
              cmd.setup_up  = 1'b1;
              state_next    = S_SHIFT;
            end
          end
          bale_pkg::OP_REM_FRONT: begin
            if (sts.empty) begin
              cmd.status_we   = 1'b1;
              cmd.status_code = bale_pkg::ST_EMPTY;
            end else begin
              cmd.use_front  = 1'b1;
              cmd.setup_down = 1'b1;
              state_next     = S_SHIFT;
            end
          end
          bale_pkg::OP_CLEAR: begin
            cmd.len_op = bale_pkg::LEN_CLR;
          end
          bale_pkg::OP_SEARCH_GT: begin
            cmd.setup_srch = 1'b1;
            state_next     = S_SEARCH;
          end
          default: begin
            state_next = S_DONE;
          end
        endcase
      end
      S_RDWAIT: begin
        cmd.cap_rdata = 1'b1;
        state_next    = S_DONE;
      end
      // Tail move, then the new value goes into the gap for inserts
      S_SHIFT: begin
        if (sts.walk_done) begin
          if ((sts.op == bale_pkg::OP_INS_AT) || (sts.op == bale_pkg::OP_INS_FRONT)) begin
            cmd.mem_wr = 1'b1;
            cmd.wr_sel = bale_pkg::WA_BASE;
            cmd.len_op = bale_pkg::LEN_INC;
          end else begin
            cmd.len_op = bale_pkg::LEN_DEC;
          end
          state_next = S_DONE;
        end else begin
          cmd.step = 1'b1;
        end
      end
      S_SEARCH: begin
        if (sts.search_done) begin
          state_next = S_DONE;
        end else begin
          cmd.step = 1'b1;
        end
      end
      S_DONE: begin
        if (sts.out_free) begin
          cmd.res_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule
